@@ rtl/core/vt_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// vt_pkg: shared types and constants for the vertex transform engine
// Word format, matrix layout and lane interface types.
// ---------------------------------------------------------------------------
package vt_pkg;

  localparam int unsigned DataW    = 32;
  localparam int unsigned FracBits = 16;
  localparam int unsigned Dim      = 4;
  localparam int unsigned RowIdxW  = $clog2(Dim);

  // Exact product, product after the fraction shift, pair sum and full sum
  localparam int unsigned ProdW = 2 * DataW;
  localparam int unsigned ShW   = ProdW - FracBits;
  localparam int unsigned PairW = ShW + 1;
  localparam int unsigned SumW  = ShW + 2;

  typedef logic [DataW-1:0] word_t;
  typedef word_t [Dim-1:0]  vec_t;
  typedef vec_t  [Dim-1:0]  mat_t;

  typedef enum logic {
    REQ_LOAD      = 1'b0,
    REQ_TRANSFORM = 1'b1
  } req_type_e;

  // Stage enables driven by the pipeline control in the top level
  typedef struct packed {
    logic en_mul;
    logic en_add;
    logic en_sat;
  } lane_ctrl_t;

  typedef struct packed {
    word_t data;
    logic  sat;
  } lane_res_t;

  typedef lane_res_t [Dim-1:0] lane_res_vec_t;

endpackage

@@ rtl/core/vt_matrix.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// vt_matrix: transform matrix storage
// Holds the 4x4 matrix, resets it to the identity and writes one row per
// load request.
// ---------------------------------------------------------------------------
module vt_matrix (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     wr_en_i,
  input  logic [vt_pkg::RowIdxW-1:0] wr_row_i,
  input  vt_pkg::vec_t             wr_data_i,
  output vt_pkg::mat_t             mat_o
);

  localparam vt_pkg::word_t One = vt_pkg::word_t'(1) << vt_pkg::FracBits;

  vt_pkg::mat_t mat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < vt_pkg::Dim; r++) begin
        for (int c = 0; c < vt_pkg::Dim; c++) begin
          mat_q[r][c] <= (r == c) ? One : '0;
        end
      end
    end else if (wr_en_i) begin
      mat_q[wr_row_i] <= wr_data_i;
    end
  end

  assign mat_o = mat_q;

endmodule

@@ rtl/core/vt_lane.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// vt_lane: one row dot product lane
// Multiplies a matrix row by the vector, floors each product, sums and
// saturates over three register stages.
// ---------------------------------------------------------------------------
module vt_lane (
  input  logic               clk_i,
  input  vt_pkg::lane_ctrl_t ctrl_i,
  input  vt_pkg::vec_t       row_i,
  input  vt_pkg::vec_t       vec_i,
  output vt_pkg::lane_res_t  res_o
);

  localparam int unsigned SumW = vt_pkg::SumW;
  localparam logic signed [SumW-1:0] MaxV = SumW'(32'sh7fff_ffff);
  localparam logic signed [SumW-1:0] MinV = SumW'(32'sh8000_0000);

  logic signed [vt_pkg::ProdW-1:0] prod_q [vt_pkg::Dim];
  logic signed [vt_pkg::ShW-1:0]   sh     [vt_pkg::Dim];
  logic signed [vt_pkg::PairW-1:0] pair_d [2];
  logic signed [vt_pkg::PairW-1:0] pair_q [2];
  logic signed [SumW-1:0]          sum;
  vt_pkg::lane_res_t               res_d;
  vt_pkg::lane_res_t               res_q;

  // Stage 1: exact products
  always_ff @(posedge clk_i) begin
    if (ctrl_i.en_mul) begin
      for (int c = 0; c < vt_pkg::Dim; c++) begin
        prod_q[c] <= $signed(row_i[c]) * $signed(vec_i[c]);
      end
    end
  end

  // Stage 2: floor by the fraction shift, add in pairs
  always_comb begin
    for (int c = 0; c < vt_pkg::Dim; c++) begin
      sh[c] = vt_pkg::ShW'(prod_q[c] >>> vt_pkg::FracBits);
    end
    pair_d[0] = vt_pkg::PairW'(sh[0]) + vt_pkg::PairW'(sh[1]);
    pair_d[1] = vt_pkg::PairW'(sh[2]) + vt_pkg::PairW'(sh[3]);
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en_add) begin
      pair_q <= pair_d;
    end
  end

  // Stage 3: final add and clamp to the word range
  always_comb begin
    sum = SumW'(pair_q[0]) + SumW'(pair_q[1]);
    if (sum > MaxV) begin
      res_d.data = MaxV[vt_pkg::DataW-1:0];
      res_d.sat  = 1'b1;
    end else if (sum < MinV) begin
      res_d.data = MinV[vt_pkg::DataW-1:0];
      res_d.sat  = 1'b1;
    end else begin
      res_d.data = sum[vt_pkg::DataW-1:0];
      res_d.sat  = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en_sat) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

@@ rtl/core/vt_merge.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// vt_merge: result merge and output register
// Gathers the four lane sums into one result and folds the lane
// saturation flags together.
// ---------------------------------------------------------------------------
module vt_merge (
  input  logic                  clk_i,
  input  logic                  en_i,
  input  vt_pkg::lane_res_vec_t lanes_i,
  output vt_pkg::vec_t          data_o,
  output logic                  sat_o
);

  vt_pkg::vec_t data_q;
  vt_pkg::vec_t data_d;
  logic         sat_q;
  logic         sat_d;

  always_comb begin
    sat_d = 1'b0;
    for (int r = 0; r < vt_pkg::Dim; r++) begin
      data_d[r] = lanes_i[r].data;
      sat_d     = sat_d | lanes_i[r].sat;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
      sat_q  <= sat_d;
    end
  end

  assign data_o = data_q;
  assign sat_o  = sat_q;

endmodule

@@ rtl/core/vertex_transform_4x4_top.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// vertex_transform_4x4_top: 4x4 Q16.16 matrix times vector engine
// Top level: matrix store, four row lanes, merge stage and flow control.
// ---------------------------------------------------------------------------
// One request is taken per clock while in_ready_o is high, loads and
// transforms alike. A load writes one matrix row at the edge it is
// accepted and returns nothing; a transform accepted in the next cycle
// already sees that row. A transform result passes the three stages in
// each of the four row lanes (multiply, floor and pair add, final add
// and clamp) and the output register of the merge stage. With the output
// side always ready the block sustains one vector per clock; a stalled
// output fills the four stages before the input is held off. The matrix
// is the identity after reset.
// ---------------------------------------------------------------------------
module vertex_transform_4x4_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        req_type_i,
  input  logic [vt_pkg::RowIdxW-1:0]  row_index_i,
  input  logic signed [31:0]          val_0_i,
  input  logic signed [31:0]          val_1_i,
  input  logic signed [31:0]          val_2_i,
  input  logic signed [31:0]          val_3_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic signed [31:0]          out_x_o,
  output logic signed [31:0]          out_y_o,
  output logic signed [31:0]          out_z_o,
  output logic signed [31:0]          out_w_o,
  output logic                        saturated_o
);

  logic                  accept;
  logic                  is_xform;
  vt_pkg::vec_t          vals;
  vt_pkg::mat_t          mat;
  vt_pkg::lane_ctrl_t    ctrl;
  vt_pkg::lane_res_vec_t lane_res;
  vt_pkg::vec_t          out_data;
  logic                  en_out;

  logic v_mul_q, v_mul_d;
  logic v_add_q, v_add_d;
  logic v_sat_q, v_sat_d;
  logic v_out_q, v_out_d;

  assign vals = {vt_pkg::word_t'(val_3_i), vt_pkg::word_t'(val_2_i),
                 vt_pkg::word_t'(val_1_i), vt_pkg::word_t'(val_0_i)};

  // Each stage advances when it is empty or its successor advances
  assign en_out      = !v_out_q || out_ready_i;
  assign ctrl.en_sat = !v_sat_q || en_out;
  assign ctrl.en_add = !v_add_q || ctrl.en_sat;
  assign ctrl.en_mul = !v_mul_q || ctrl.en_add;

  assign in_ready_o = ctrl.en_mul;
  assign accept     = in_valid_i && in_ready_o;
  assign is_xform   = (vt_pkg::req_type_e'(req_type_i) == vt_pkg::REQ_TRANSFORM);

  always_comb begin
    v_mul_d = ctrl.en_mul ? (accept && is_xform) : v_mul_q;
    v_add_d = ctrl.en_add ? v_mul_q : v_add_q;
    v_sat_d = ctrl.en_sat ? v_add_q : v_sat_q;
    v_out_d = en_out      ? v_sat_q : v_out_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_mul_q <= 1'b0;
      v_add_q <= 1'b0;
      v_sat_q <= 1'b0;
      v_out_q <= 1'b0;
    end else begin
      v_mul_q <= v_mul_d;
      v_add_q <= v_add_d;
      v_sat_q <= v_sat_d;
      v_out_q <= v_out_d;
    end
  end

  vt_matrix u_matrix (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (accept && !is_xform),
    .wr_row_i  (row_index_i),
    .wr_data_i (vals),
    .mat_o     (mat)
  );

  for (genvar r = 0; r < vt_pkg::Dim; r++) begin : g_lane
    vt_lane u_lane (
      .clk_i  (clk_i),
      .ctrl_i (ctrl),
      .row_i  (mat[r]),
      .vec_i  (vals),
      .res_o  (lane_res[r])
    );
  end

  vt_merge u_merge (
    .clk_i   (clk_i),
    .en_i    (en_out),
    .lanes_i (lane_res),
    .data_o  (out_data),
    .sat_o   (saturated_o)
  );

  assign out_valid_o = v_out_q;
  assign out_x_o     = $signed(out_data[0]);
  assign out_y_o     = $signed(out_data[1]);
  assign out_z_o     = $signed(out_data[2]);
  assign out_w_o     = $signed(out_data[3]);

endmodule
